// ----- sv/esa_pkg.sv -----
package esa_pkg;

  localparam int NUM_SECTORS = 8;
  localparam int NUM_POS = 20;
  localparam logic [4:0] POS_MAX = 5'd19;
  localparam logic [15:0] SPEED_MAX = 16'hFFFF;
  localparam logic [7:0] MIN_GAP_RESET = 8'd3;
  localparam logic [19:0] SCALE_RESET = 20'd14476;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b1;

  typedef struct packed {
    logic        clk_level;
    logic        dt_level;
    logic        button_pressed;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  position;
    logic [2:0]  sector;
    logic [15:0] speed;
    logic        pulse_accepted;
    logic        lap_complete;
    logic [15:0] sector_average;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic pulse_update;
    logic avg_start;
    logic avg_store;
    logic finish;
    logic emit_avg;
    logic [2:0] emit_sector;
  } cmd_t;

  typedef struct packed {
    logic pulse;
    logic need_div;
    logic lap;
    logic div_done;
    logic cnt_nonzero;
  } status_t;

  function automatic logic [2:0] sector_of(input logic [4:0] p);
    if (p < 5'd3) return 3'd0;
    if (p < 5'd5) return 3'd1;
    if (p < 5'd8) return 3'd2;
    if (p < 5'd10) return 3'd3;
    if (p < 5'd13) return 3'd4;
    if (p < 5'd15) return 3'd5;
    if (p < 5'd18) return 3'd6;
    return 3'd7;
  endfunction

endpackage

// ----- sv/esa_divider.sv -----
module esa_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/esa_datapath.sv -----
module esa_datapath #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [esa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  esa_pkg::in_item_t    item,
  input  esa_pkg::cmd_t        cmd,
  input  logic [2:0]           avg_idx,
  output esa_pkg::status_t     status,
  output esa_pkg::out_item_t   result
);

  logic [7:0]  min_gap_ms;
  logic [19:0] speed_scale;
  logic        clk_prev;
  logic [4:0]  position_count;
  logic [31:0] last_valid_ms;
  logic [31:0] last_pulse_ms;
  logic        first_pulse;
  logic [15:0] speed_now;
  logic [31:0] sector_sum [esa_pkg::NUM_SECTORS];
  logic [COUNT_WIDTH-1:0] sector_count [esa_pkg::NUM_SECTORS];
  logic [15:0] sector_avg [esa_pkg::NUM_SECTORS];

  esa_pkg::in_item_t cur;
  logic        pulse_r, lap_r, need_div_r;
  logic [4:0]  pos_new;
  logic [2:0]  sec_new;
  logic [31:0] delta;
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q;
  logic [32:0] sum_add;
  logic [4:0]  pos_out;

  logic [4:0] p0;
  logic       is_pulse;
  assign p0 = (position_count >= 5'(esa_pkg::NUM_POS)) ? 5'd0 : position_count;
  assign is_pulse = clk_prev && !cur.clk_level &&
                    ((cur.now_ms - last_valid_ms) >= {24'd0, min_gap_ms});
  assign delta = cur.now_ms - last_pulse_ms;
  assign pos_new = (cur.dt_level != cur.clk_level) ?
                   ((p0 == esa_pkg::POS_MAX) ? 5'd0 : p0 + 5'd1) :
                   ((p0 == 5'd0) ? esa_pkg::POS_MAX : p0 - 5'd1);
  assign sec_new = esa_pkg::sector_of(pos_new);

  assign div_start = cmd.div_start || cmd.avg_start;
  assign div_a = cmd.avg_start ? sector_sum[avg_idx] : {12'd0, speed_scale};
  assign div_b = cmd.avg_start ? 32'(sector_count[avg_idx]) : delta;

  esa_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .quotient(div_q), .done(div_done)
  );

  logic [15:0] speed_upd;
  always_comb begin
    speed_upd = speed_now;
    if (need_div_r) begin
      if (delta == 32'd0) speed_upd = esa_pkg::SPEED_MAX;
      else if (div_q > 32'hFFFF) speed_upd = esa_pkg::SPEED_MAX;
      else speed_upd = div_q[15:0];
    end
  end
  assign sum_add = {1'b0, sector_sum[sec_new]} + {17'd0, speed_upd};

  assign status.pulse = pulse_r;
  assign status.need_div = need_div_r;
  assign status.lap = lap_r;
  assign status.div_done = div_done;
  assign status.cnt_nonzero = sector_count[avg_idx] != '0;

  assign pos_out = position_count;

  always_comb begin
    result.kind = cmd.emit_avg;
    result.position = pos_out;
    result.sector = cmd.emit_avg ? cmd.emit_sector : esa_pkg::sector_of(pos_out);
    result.speed = speed_now;
    result.pulse_accepted = pulse_r;
    result.lap_complete = lap_r;
    result.sector_average = sector_avg[result.sector];
    result.last = cmd.emit_avg ? (cmd.emit_sector == 3'd7) : !lap_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_ms <= esa_pkg::MIN_GAP_RESET;
      speed_scale <= esa_pkg::SCALE_RESET;
      clk_prev <= 1'b0;
      position_count <= '0;
      last_valid_ms <= '0;
      last_pulse_ms <= '0;
      first_pulse <= 1'b1;
      speed_now <= '0;
      pulse_r <= 1'b0;
      lap_r <= 1'b0;
      need_div_r <= 1'b0;
      for (int i = 0; i < esa_pkg::NUM_SECTORS; i++) begin
        sector_sum[i] <= '0;
        sector_count[i] <= '0;
        sector_avg[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == esa_pkg::REG_MIN_GAP) min_gap_ms <= cfg_data[7:0];
        else speed_scale <= cfg_data;
      end
      if (cmd.load) begin
        cur <= item;
        lap_r <= 1'b0;
        pulse_r <= 1'b0;
      end
      if (cmd.div_start) begin
        pulse_r <= is_pulse;
        need_div_r <= is_pulse && !first_pulse;
      end
      if (cmd.pulse_update) begin
        if (pulse_r) begin
          speed_now <= speed_upd;
          first_pulse <= 1'b0;
          last_valid_ms <= cur.now_ms;
          last_pulse_ms <= cur.now_ms;
          position_count <= pos_new;
          sector_sum[sec_new] <= sum_add[32] ? 32'hFFFFFFFF : sum_add[31:0];
          if (sector_count[sec_new] != {COUNT_WIDTH{1'b1}})
            sector_count[sec_new] <= sector_count[sec_new] + 1'b1;
          lap_r <= (p0 == esa_pkg::POS_MAX && pos_new == 5'd0) ||
                   (p0 == 5'd0 && pos_new == esa_pkg::POS_MAX);
        end else begin
          position_count <= p0;
        end
      end
      if (cmd.avg_store) begin
        if (sector_count[avg_idx] != '0)
          sector_avg[avg_idx] <= (div_q > 32'hFFFF) ? esa_pkg::SPEED_MAX : div_q[15:0];
        sector_sum[avg_idx] <= '0;
        sector_count[avg_idx] <= '0;
      end
      if (cmd.finish) begin
        clk_prev <= cur.clk_level;
        if (cur.button_pressed) position_count <= '0;
      end
    end
  end

endmodule

// ----- sv/esa_controller.sv -----
module esa_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  esa_pkg::status_t status,
  output esa_pkg::cmd_t    cmd,
  output logic [2:0]       avg_idx
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV, S_UPDATE, S_AVG_GO, S_AVG_WAIT, S_FINISH, S_EMIT
  } state_t;

  state_t     state;
  logic [3:0] emit_cnt;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_EMIT;

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.div_start = state == S_CHECK;
    cmd.pulse_update = state == S_UPDATE;
    cmd.avg_start = state == S_AVG_GO;
    cmd.avg_store = state == S_AVG_WAIT && status.div_done;
    cmd.finish = state == S_FINISH;
    cmd.emit_avg = emit_cnt != 4'd0;
    cmd.emit_sector = 3'(emit_cnt - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      emit_cnt <= '0;
      avg_idx <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: state <= S_DIV;
        S_DIV: if (!status.need_div || status.div_done) state <= S_UPDATE;
        S_UPDATE: begin
          avg_idx <= '0;
          state <= S_AVG_GO;
        end
        S_AVG_GO: state <= status.lap ? S_AVG_WAIT : S_FINISH;
        S_AVG_WAIT: if (status.div_done) begin
          avg_idx <= avg_idx + 3'd1;
          state <= (avg_idx == 3'd7) ? S_FINISH : S_AVG_GO;
        end
        S_FINISH: begin
          emit_cnt <= '0;
          state <= S_EMIT;
        end
        S_EMIT: if (out_ready) begin
          if (!status.lap || emit_cnt == 4'd8) state <= S_IDLE;
          else emit_cnt <= emit_cnt + 4'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/encoder_sector_speed_averager.sv -----
// encoder sector speed averager
// in channel: in_valid/in_ready with in_data (pin levels and ms timestamp)
// out channel: out_valid/out_ready with out_data; one status request per
// sample, plus eight sector average requests 0..7 after a lap
// config: cfg_we writes cfg_data to register cfg_index (0 gap, 1 scale);
// write only while the block is idle, which the block does not enforce
// divider: one shared 32-step divider for the speed division and the
// lap averages
// flow: one sample at a time, next accepted after the last request
// is taken
// reset: synchronous rst clears position, timers, sums, counts and
// averages and restores register defaults
// a stalled receiver holds the request steady and the block takes no
// new sample until it is drained
module encoder_sector_speed_averager #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  esa_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output esa_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [esa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esa_pkg::CFG_DATA_W-1:0] cfg_data
);

  esa_pkg::cmd_t    cmd;
  esa_pkg::status_t status;
  logic [2:0]       avg_idx;

  esa_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .cmd(cmd), .avg_idx(avg_idx)
  );

  esa_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(in_data), .cmd(cmd), .avg_idx(avg_idx),
    .status(status), .result(out_data)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept while emitting");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.position <= esa_pkg::POS_MAX) else $error("position range");
  a_lap_pulse: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.lap_complete) |-> out_data.pulse_accepted)
    else $error("lap without pulse");

endmodule

// ----- verif/encoder_sector_speed_averager_checker.sv -----
`timescale 1ns / 1ps

module encoder_sector_speed_averager_checker #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  esa_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  esa_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [esa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             laps_seen
);

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_AVG = 1'b1;

  logic [7:0]             gap_ms;
  logic [19:0]            scale;
  logic                   pin_prev;
  logic [4:0]             pos;
  logic [31:0]            valid_ms;
  logic [31:0]            pulse_ms;
  logic                   awaiting_first;
  logic [15:0]            speed_q;
  logic [31:0]            acc_sum [esa_pkg::NUM_SECTORS];
  logic [COUNT_WIDTH-1:0] acc_cnt [esa_pkg::NUM_SECTORS];
  logic [15:0]            avg_store [esa_pkg::NUM_SECTORS];
  esa_pkg::out_item_t     expected_results [$];

  function automatic logic [2:0] compass_sector(input logic [4:0] p);
    case (p)
      5'd0, 5'd1, 5'd2:    return 3'd0;
      5'd3, 5'd4:          return 3'd1;
      5'd5, 5'd6, 5'd7:    return 3'd2;
      5'd8, 5'd9:          return 3'd3;
      5'd10, 5'd11, 5'd12: return 3'd4;
      5'd13, 5'd14:        return 3'd5;
      5'd15, 5'd16, 5'd17: return 3'd6;
      default:             return 3'd7;
    endcase
  endfunction

  task automatic predict_sample(input esa_pkg::in_item_t it);
    logic               pulse;
    logic               lap;
    logic [4:0]         prev;
    logic [2:0]         s;
    logic [31:0]        delta;
    logic [31:0]        q;
    esa_pkg::out_item_t r;
    pulse = 1'b0;
    lap = 1'b0;
    if (pos >= esa_pkg::NUM_POS) pos = '0;
    if (pin_prev && !it.clk_level && (it.now_ms - valid_ms) >= {24'd0, gap_ms}) begin
      pulse = 1'b1;
      prev = pos;
      valid_ms = it.now_ms;
      if (!awaiting_first) begin
        delta = it.now_ms - pulse_ms;
        if (delta == 0) begin
          speed_q = esa_pkg::SPEED_MAX;
        end else begin
          q = {12'd0, scale} / delta;
          speed_q = (q > 32'hFFFF) ? esa_pkg::SPEED_MAX : q[15:0];
        end
      end else begin
        awaiting_first = 1'b0;
      end
      pulse_ms = it.now_ms;
      if (it.dt_level != it.clk_level)
        pos = (prev == esa_pkg::POS_MAX) ? 5'd0 : prev + 5'd1;
      else pos = (prev == 5'd0) ? esa_pkg::POS_MAX : prev - 5'd1;
      s = compass_sector(pos);
      acc_sum[s] = (acc_sum[s] > 32'hFFFFFFFF - speed_q) ? 32'hFFFFFFFF
                   : acc_sum[s] + speed_q;
      if (acc_cnt[s] != '1) acc_cnt[s] = acc_cnt[s] + 1'b1;
      if ((prev == esa_pkg::POS_MAX && pos == 5'd0) ||
          (prev == 5'd0 && pos == esa_pkg::POS_MAX)) begin
        lap = 1'b1;
        for (int i = 0; i < esa_pkg::NUM_SECTORS; i++) begin
          if (acc_cnt[i] != 0) begin
            q = acc_sum[i] / acc_cnt[i];
            avg_store[i] = (q > 32'hFFFF) ? esa_pkg::SPEED_MAX : q[15:0];
          end
          acc_sum[i] = '0;
          acc_cnt[i] = '0;
        end
      end
    end
    pin_prev = it.clk_level;
    if (it.button_pressed) pos = '0;
    s = compass_sector(pos);
    r = '{KIND_STATUS, pos, s, speed_q, pulse, lap, avg_store[s], !lap};
    expected_results.push_back(r);
    if (lap) begin
      for (int i = 0; i < esa_pkg::NUM_SECTORS; i++) begin
        r = '{KIND_AVG, pos, 3'(i), speed_q, pulse, 1'b1, avg_store[i],
              i == esa_pkg::NUM_SECTORS - 1};
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic compare_result(input esa_pkg::out_item_t got);
    esa_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected request: %p", got);
      return;
    end
    want = expected_results.pop_front();
    if (want.kind !== got.kind || want.position !== got.position ||
        want.sector !== got.sector || want.speed !== got.speed ||
        want.pulse_accepted !== got.pulse_accepted ||
        want.lap_complete !== got.lap_complete ||
        want.sector_average !== got.sector_average || want.last !== got.last) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch at %0t", $time);
        $display("  expected %p", want);
        $display("  actual   %p", got);
      end
    end
    if (want.kind == KIND_AVG && want.last) laps_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gap_ms = esa_pkg::MIN_GAP_RESET;
      scale = esa_pkg::SCALE_RESET;
      pin_prev = 1'b0;
      pos = '0;
      valid_ms = '0;
      pulse_ms = '0;
      awaiting_first = 1'b1;
      speed_q = '0;
      for (int i = 0; i < esa_pkg::NUM_SECTORS; i++) begin
        acc_sum[i] = '0;
        acc_cnt[i] = '0;
        avg_store[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == esa_pkg::REG_MIN_GAP) gap_ms = cfg_data[7:0];
        else if (cfg_index == esa_pkg::REG_SCALE) scale = cfg_data;
      end
      if (out_valid && out_ready) compare_result(out_data);
      if (in_valid && in_ready) predict_sample(in_data);
    end
    pending <= expected_results.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    laps_seen = 0;
  end

endmodule

// ----- verif/encoder_sector_speed_averager_tb.sv -----
`timescale 1ns / 1ps

module encoder_sector_speed_averager_tb;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  esa_pkg::in_item_t              in_data;
  logic                           out_valid;
  logic                           out_ready;
  esa_pkg::out_item_t             out_data;
  logic                           cfg_we;
  logic [esa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [esa_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             errors;
  int                             pending;
  int                             laps_seen;

  logic [31:0] now_ms;
  logic        calm;
  logic        hold_req;
  int          samples_sent;
  int          random_sent;
  int          settings_used;

  encoder_sector_speed_averager #(.COUNT_WIDTH(16)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  encoder_sector_speed_averager_checker #(.COUNT_WIDTH(16)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .laps_seen(laps_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  // response side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (700) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  task automatic send_sample(input logic c, input logic d, input logic b,
                             input logic [31:0] ms);
    in_data <= '{c, d, b, ms};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // one clock-pin cycle: high sample, then falling sample after gap ms
  task automatic turn(input logic up, input logic [31:0] gap, input logic btn);
    now_ms = now_ms + 1;
    send_sample(1'b1, 1'($urandom_range(1)), 1'b0, now_ms);
    now_ms = now_ms + gap;
    send_sample(1'b0, up, btn, now_ms);
  endtask

  task automatic write_reg(input logic [esa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [esa_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] gap, input logic [19:0] scale);
    write_reg(esa_pkg::REG_MIN_GAP, {12'd0, gap});
    write_reg(esa_pkg::REG_SCALE, scale);
    settings_used++;
  endtask

  task automatic random_phase(input int n_items);
    logic [7:0]  gap;
    logic        up;
    int          start;
    int          pick;
    gap = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
    set_config(gap, 20'($urandom_range(1, 20'hFFFFF)));
    up = 1'($urandom_range(1));
    start = samples_sent;
    while (samples_sent - start < n_items) begin
      if (random_sent == 60) calm = 1'b1;
      if (random_sent == 110) calm = 1'b0;
      if (random_sent == 140) hold_req = 1'b1;
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) up = !up;
      if (pick < 80) begin
        turn(up, gap + $urandom_range(40), $urandom_range(49) == 0);
      end else if (pick < 88) begin
        turn(up, $urandom_range(gap), 1'b0);
      end else begin
        now_ms = $urandom;
        send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), now_ms);
      end
      random_sent++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    samples_sent = 0;
    random_sent = 0;
    settings_used = 1;
    now_ms = 32'd100;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first pulse, normal speed, rejected edge, button, laps both ways
    turn(1'b1, 10, 1'b0);
    turn(1'b1, 5, 1'b0);
    turn(1'b1, 1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1, now_ms);
    for (int i = 0; i < 20; i++) turn(1'b1, 4, 1'b0);
    turn(1'b0, 4, 1'b0);

    // no debounce, largest scale: saturation, zero interval, timestamp wrap
    set_config(8'd0, 20'hFFFFF);
    turn(1'b1, 1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, now_ms);
    send_sample(1'b0, 1'b1, 1'b0, now_ms);
    now_ms = 32'hFFFF_FFF8;
    turn(1'b0, 3, 1'b0);
    turn(1'b0, 3, 1'b0);
    turn(1'b0, 3, 1'b0);

    // widest gap, smallest scale
    set_config(8'd255, 20'd1);
    turn(1'b1, 300, 1'b0);
    turn(1'b1, 100, 1'b0);

    // scale of zero
    set_config(8'd0, 20'd0);
    turn(1'b1, 5, 1'b0);

    for (int p = 0; p < 4; p++) random_phase(92);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d samples over %0d register settings, %0d laps averaged",
             samples_sent, settings_used, laps_seen);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- encoder_sector_speed_averager.f -----
sv/esa_pkg.sv
sv/esa_divider.sv
sv/esa_datapath.sv
sv/esa_controller.sv
sv/encoder_sector_speed_averager.sv
verif/encoder_sector_speed_averager_checker.sv
verif/encoder_sector_speed_averager_tb.sv
